>>> rtl/mnw_pkg.sv
// shared types and constants of the markov note walker
package mnw_pkg;

  localparam int KIND_W    = 3;
  localparam int NOTE_W    = 7;
  localparam int LEN_W     = 16;
  localparam int VEL_W     = 7;
  localparam int IDX_W     = 6;
  localparam int WIN_W     = 16;
  localparam int TRACK_W   = 4;
  localparam int RAND_BITS = 31;
  localparam int DIV_CNT_W = $clog2(RAND_BITS);

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE_VERTEX = 3'd0,
    KIND_ADD_EDGE     = 3'd1,
    KIND_SET_START    = 3'd2,
    KIND_BEGIN        = 3'd3,
    KIND_STEP         = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_EDGE_WR,
    ST_STEP_CNT,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_CHK,
    ST_DIV,
    ST_WALK_RD,
    ST_WALK_CMP,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic latch_item;
    logic clear_wr;
    logic vertex_wr;
    logic edge_add;
    logic start_wr;
    logic begin_ld;
    logic step_init;
    logic sum_acc;
    logic chk;
    logic div_step;
    logic walk_cmp;
    logic result_load;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              clear_done;
    logic              cnt_zero;
    logic              k_last;
    logic              total_zero;
    logic              div_done;
    logic              walk_hit;
    logic              res_empty;
  } sts_t;

endpackage

>>> rtl/mnw_channels.sv
// item and event channel interfaces
interface mnw_item_if;
  logic                              valid;
  logic                              ready;
  logic [mnw_pkg::KIND_W-1:0]        kind;
  logic [mnw_pkg::IDX_W-1:0]         vertex_index;
  logic [mnw_pkg::IDX_W-1:0]         target_index;
  logic [mnw_pkg::WIN_W-1:0]         weight;
  logic [mnw_pkg::NOTE_W-1:0]        note_number;
  logic [mnw_pkg::LEN_W-1:0]         note_length;
  logic [mnw_pkg::VEL_W-1:0]         loudness;
  logic [mnw_pkg::TRACK_W-1:0]       track;
  logic [mnw_pkg::RAND_BITS-1:0]     random_value;

  modport source (output valid, kind, vertex_index, target_index, weight, note_number,
                  note_length, loudness, track, random_value, input ready);
  modport sink (input valid, kind, vertex_index, target_index, weight, note_number,
                note_length, loudness, track, random_value, output ready);
  modport monitor (input valid, ready, kind, vertex_index, target_index, weight,
                   note_number, note_length, loudness, track, random_value);
endinterface

interface mnw_event_if;
  logic                       valid;
  logic                       ready;
  logic [mnw_pkg::NOTE_W-1:0] out_note;
  logic [mnw_pkg::VEL_W-1:0]  out_velocity;
  logic [mnw_pkg::LEN_W-1:0]  out_time;
  logic                       note_on;
  logic                       last;
  logic                       status;

  modport source (output valid, out_note, out_velocity, out_time, note_on, last, status,
                  input ready);
  modport sink (input valid, out_note, out_velocity, out_time, note_on, last, status,
                output ready);
endinterface

>>> rtl/mnw_ctrl.sv
// sequencing state machine of the note walker
module mnw_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  mnw_pkg::sts_t   sts,
  output mnw_pkg::cmd_t   cmd
);

  mnw_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mnw_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mnw_pkg::ST_CLEAR: begin
        if (sts.clear_done) state_next = mnw_pkg::ST_IDLE;
      end
      mnw_pkg::ST_IDLE: begin
        if (item_valid) state_next = mnw_pkg::ST_DECODE;
      end
      mnw_pkg::ST_DECODE: begin
        unique case (sts.kind)
          mnw_pkg::KIND_ADD_EDGE: state_next = mnw_pkg::ST_EDGE_WR;
          mnw_pkg::KIND_STEP:     state_next = mnw_pkg::ST_STEP_CNT;
          default:                state_next = mnw_pkg::ST_IDLE;
        endcase
      end
      mnw_pkg::ST_EDGE_WR: state_next = mnw_pkg::ST_IDLE;
      mnw_pkg::ST_STEP_CNT: begin
        state_next = sts.cnt_zero ? mnw_pkg::ST_LOAD : mnw_pkg::ST_SUM_RD;
      end
      mnw_pkg::ST_SUM_RD: state_next = mnw_pkg::ST_SUM_ACC;
      mnw_pkg::ST_SUM_ACC: begin
        state_next = sts.k_last ? mnw_pkg::ST_CHK : mnw_pkg::ST_SUM_RD;
      end
      mnw_pkg::ST_CHK: begin
        state_next = sts.total_zero ? mnw_pkg::ST_LOAD : mnw_pkg::ST_DIV;
      end
      mnw_pkg::ST_DIV: begin
        if (sts.div_done) state_next = mnw_pkg::ST_WALK_RD;
      end
      mnw_pkg::ST_WALK_RD: state_next = mnw_pkg::ST_WALK_CMP;
      mnw_pkg::ST_WALK_CMP: begin
        state_next = (sts.walk_hit || sts.k_last) ? mnw_pkg::ST_LOAD : mnw_pkg::ST_WALK_RD;
      end
      mnw_pkg::ST_LOAD: begin
        if (sts.res_empty) state_next = mnw_pkg::ST_IDLE;
      end
      default: state_next = mnw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      mnw_pkg::ST_CLEAR:    cmd.clear_wr = 1'b1;
      mnw_pkg::ST_IDLE: begin
        item_ready     = 1'b1;
        cmd.latch_item = item_valid;
      end
      mnw_pkg::ST_DECODE: begin
        cmd.vertex_wr = (sts.kind == mnw_pkg::KIND_WRITE_VERTEX);
        cmd.start_wr  = (sts.kind == mnw_pkg::KIND_SET_START);
        cmd.begin_ld  = (sts.kind == mnw_pkg::KIND_BEGIN);
      end
      mnw_pkg::ST_EDGE_WR:  cmd.edge_add  = 1'b1;
      mnw_pkg::ST_STEP_CNT: cmd.step_init = 1'b1;
      mnw_pkg::ST_SUM_RD:   ;
      mnw_pkg::ST_SUM_ACC:  cmd.sum_acc   = 1'b1;
      mnw_pkg::ST_CHK:      cmd.chk       = 1'b1;
      mnw_pkg::ST_DIV:      cmd.div_step  = 1'b1;
      mnw_pkg::ST_WALK_RD:  ;
      mnw_pkg::ST_WALK_CMP: cmd.walk_cmp  = 1'b1;
      mnw_pkg::ST_LOAD:     cmd.result_load = sts.res_empty;
      default: ;
    endcase
  end

endmodule

>>> rtl/mnw_datapath.sv
// tables, divider, accumulators and result register of the note walker
module mnw_datapath #(
  parameter int VERTEX_COUNT     = 64,
  parameter int EDGES_PER_VERTEX = 8,
  parameter int TRACK_COUNT      = 16,
  parameter int WEIGHT_BITS      = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_ready,
  mnw_item_if.sink         items,
  mnw_event_if.source      events,
  input  mnw_pkg::cmd_t    cmd,
  output mnw_pkg::sts_t    sts
);

  localparam int VAW    = $clog2(VERTEX_COUNT);
  localparam int KW     = (EDGES_PER_VERTEX > 1) ? $clog2(EDGES_PER_VERTEX) : 1;
  localparam int CW     = $clog2(EDGES_PER_VERTEX + 1);
  localparam int SW     = WEIGHT_BITS + CW;
  localparam int TKW    = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
  localparam int EAW    = VAW + KW;
  localparam int EDEPTH = VERTEX_COUNT * (2 ** KW);
  localparam int VDW    = mnw_pkg::NOTE_W + mnw_pkg::LEN_W + mnw_pkg::VEL_W;

  assign items.ready = item_ready;

  // latched item
  logic [mnw_pkg::KIND_W-1:0]    it_kind;
  logic [mnw_pkg::IDX_W-1:0]     it_vi;
  logic [mnw_pkg::IDX_W-1:0]     it_ti;
  logic [mnw_pkg::WIN_W-1:0]     it_weight;
  logic [mnw_pkg::NOTE_W-1:0]    it_note;
  logic [mnw_pkg::LEN_W-1:0]     it_len;
  logic [mnw_pkg::VEL_W-1:0]     it_vel;
  logic [mnw_pkg::TRACK_W-1:0]   it_track;
  logic [mnw_pkg::RAND_BITS-1:0] rnd_sh;

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      it_kind   <= items.kind;
      it_vi     <= items.vertex_index;
      it_ti     <= items.target_index;
      it_weight <= items.weight;
      it_note   <= items.note_number;
      it_len    <= items.note_length;
      it_vel    <= items.loudness;
      it_track  <= items.track;
    end
  end

  logic vi_ok, ti_ok, tr_ok, is_step;
  logic [VAW-1:0] vi_addr;
  logic [TKW-1:0] tr_addr;

  assign vi_ok   = 32'(it_vi) < VERTEX_COUNT;
  assign ti_ok   = 32'(it_ti) < VERTEX_COUNT;
  assign tr_ok   = 32'(it_track) < TRACK_COUNT;
  assign vi_addr = VAW'(it_vi);
  assign tr_addr = TKW'(it_track);
  assign is_step = (it_kind == mnw_pkg::KIND_STEP);

  // walker position and track starts
  logic [VAW-1:0] current;
  logic [VAW-1:0] track_starts [TRACK_COUNT];

  // walk counters
  logic [KW-1:0]  k;
  logic [CW-1:0]  n_reg;
  logic [SW-1:0]  total;
  logic [SW-1:0]  acc;
  logic [SW-1:0]  rem;
  logic [mnw_pkg::DIV_CNT_W-1:0] div_cnt;
  logic           err;

  // edge count memory, cleared by a sweep after reset
  logic [CW-1:0]  cnt_mem [VERTEX_COUNT];
  logic [CW-1:0]  cnt_q;
  logic [VAW-1:0] clr_addr;
  logic [VAW-1:0] cnt_raddr;
  logic           edge_ok;

  assign cnt_raddr = is_step ? current : vi_addr;
  assign edge_ok   = vi_ok && ti_ok && (32'(cnt_q) < EDGES_PER_VERTEX);

  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      cnt_mem[clr_addr] <= '0;
    end else if (cmd.edge_add && edge_ok) begin
      cnt_mem[vi_addr] <= cnt_q + CW'(1);
    end
    cnt_q <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_wr) begin
      clr_addr <= clr_addr + VAW'(1);
    end
  end

  // vertex memory: note, duration, velocity
  logic [VDW-1:0] vtx_mem [VERTEX_COUNT];
  logic [VDW-1:0] vtx_q;
  logic [VDW-1:0] vtx_hold;

  always_ff @(posedge clk) begin
    if (cmd.vertex_wr && vi_ok) begin
      vtx_mem[vi_addr] <= {it_note, it_len, it_vel};
    end
    vtx_q <= vtx_mem[current];
  end

  // edge memories
  logic [VAW-1:0]         etgt_mem [EDEPTH];
  logic [WEIGHT_BITS-1:0] ewt_mem  [EDEPTH];
  logic [VAW-1:0]         etgt_q;
  logic [WEIGHT_BITS-1:0] ewt_q;
  logic [EAW-1:0]         e_waddr, e_raddr;

  assign e_waddr = {vi_addr, KW'(cnt_q)};
  assign e_raddr = {current, k};

  always_ff @(posedge clk) begin
    if (cmd.edge_add && edge_ok) begin
      etgt_mem[e_waddr] <= VAW'(it_ti);
      ewt_mem[e_waddr]  <= WEIGHT_BITS'(it_weight);
    end
    etgt_q <= etgt_mem[e_raddr];
    ewt_q  <= ewt_mem[e_raddr];
  end

  // restoring remainder step, one random bit per cycle
  logic [SW:0] trial;
  logic [SW:0] trial_sub;
  logic        trial_ge;
  logic [SW-1:0] acc_new;

  assign trial     = {rem, rnd_sh[mnw_pkg::RAND_BITS-1]};
  assign trial_ge  = trial >= {1'b0, total};
  assign trial_sub = trial - {1'b0, total};
  assign acc_new   = acc + SW'(ewt_q);

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      rnd_sh <= items.random_value;
    end else if (cmd.div_step) begin
      rnd_sh <= {rnd_sh[mnw_pkg::RAND_BITS-2:0], 1'b0};
    end
    if (cmd.step_init) begin
      n_reg    <= cnt_q;
      vtx_hold <= vtx_q;
      k        <= '0;
      total    <= '0;
      err      <= (cnt_q == '0);
    end
    if (cmd.sum_acc) begin
      total <= total + SW'(ewt_q);
      k     <= k + KW'(1);
    end
    if (cmd.chk) begin
      err     <= (total == '0);
      k       <= '0;
      acc     <= '0;
      rem     <= '0;
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      rem     <= trial_ge ? SW'(trial_sub) : SW'(trial);
      div_cnt <= div_cnt + mnw_pkg::DIV_CNT_W'(1);
    end
    if (cmd.walk_cmp) begin
      acc <= acc_new;
      k   <= k + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current <= '0;
      for (int t = 0; t < TRACK_COUNT; t++) begin
        track_starts[t] <= '0;
      end
    end else begin
      if (cmd.start_wr && tr_ok && vi_ok) begin
        track_starts[tr_addr] <= vi_addr;
      end
      if (cmd.begin_ld && tr_ok) begin
        current <= track_starts[tr_addr];
      end else if (cmd.walk_cmp && sts.walk_hit) begin
        current <= etgt_q;
      end
    end
  end

  // result register: two events per step
  logic [1:0]                  res_count;
  logic [mnw_pkg::NOTE_W-1:0]  res_note;
  logic [mnw_pkg::LEN_W-1:0]   res_len;
  logic [mnw_pkg::VEL_W-1:0]   res_vel;
  logic                        res_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_count <= '0;
    end else if (cmd.result_load) begin
      res_count <= 2'd2;
    end else if (events.valid && events.ready) begin
      res_count <= res_count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      {res_note, res_len, res_vel} <= vtx_hold;
      res_err                      <= err;
    end
  end

  assign events.valid        = (res_count != 2'd0);
  assign events.note_on      = (res_count == 2'd2);
  assign events.last         = (res_count == 2'd1);
  assign events.out_note     = res_note;
  assign events.out_velocity = res_vel;
  assign events.out_time     = events.note_on ? '0 : res_len;
  assign events.status       = res_err;

  assign sts.kind       = it_kind;
  assign sts.clear_done = (clr_addr == VAW'(VERTEX_COUNT - 1));
  assign sts.cnt_zero   = (cnt_q == '0);
  assign sts.k_last     = ((CW + 1)'(k) + (CW + 1)'(1)) == (CW + 1)'(n_reg);
  assign sts.total_zero = (total == '0);
  assign sts.div_done   = (div_cnt == mnw_pkg::DIV_CNT_W'(mnw_pkg::RAND_BITS - 1));
  assign sts.walk_hit   = rem < acc_new;
  assign sts.res_empty  = (res_count == 2'd0);

endmodule

>>> rtl/markov_note_walker.sv
// top level of the markov note walker
//
//   channel | direction | contents
//   items   | in        | load, begin and step commands with random value
//   events  | out       | note-on then note-off event per step
//
// loads, begins and ignored items go through decode back to ready; edge adds also pass edge write
// a step reads the edge count, sums the weights of all its edges, forms the remainder of the
// random value by that sum one bit at a time, then walks the edges until the running sum passes it
// after reset a sweep clears the edge counts of all vertices before items are taken
// a stalled event output holds the next step in its load state until both events are gone
module markov_note_walker #(
  parameter int VERTEX_COUNT     = 64,
  parameter int EDGES_PER_VERTEX = 8,
  parameter int TRACK_COUNT      = 16,
  parameter int WEIGHT_BITS      = 16
) (
  input  logic         clk,
  input  logic         rst,
  mnw_item_if.sink     items,
  mnw_event_if.source  events
);

  mnw_pkg::cmd_t cmd;
  mnw_pkg::sts_t sts;
  logic          item_ready;

  mnw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (items.valid),
    .item_ready (item_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  mnw_datapath #(
    .VERTEX_COUNT     (VERTEX_COUNT),
    .EDGES_PER_VERTEX (EDGES_PER_VERTEX),
    .TRACK_COUNT      (TRACK_COUNT),
    .WEIGHT_BITS      (WEIGHT_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .item_ready (item_ready),
    .items      (items),
    .events     (events),
    .cmd        (cmd),
    .sts        (sts)
  );

  a_load_into_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |-> !events.valid)
    else $error("result register overwritten");

  a_off_follows_on: assert property (@(posedge clk) disable iff (rst)
    (events.valid && events.ready && events.note_on) |=> (events.valid && events.last))
    else $error("note-off event missing after note-on");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear_wr, cmd.edge_add, cmd.latch_item}))
    else $error("conflicting count memory commands");

  a_no_items_in_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_wr |-> !items.ready)
    else $error("item taken during clearing sweep");

endmodule
